### rtl/core/slsfp_pkg.sv
// Package for the sync/length/sum frame parser.
// Holds the status codes, register indexes and field widths shared by the core and its checker.
// No dependencies.
`timescale 1ns / 1ps

package slsfp_pkg;

    // Field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TDATA_W  = 24;

    // Per-byte parse status codes.
    localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDX_FIRST_SYNC  = 1'b0;
    localparam logic CFG_IDX_SECOND_SYNC = 1'b1;

    // Reset values of the sync byte registers.
    localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'hA5;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'h5A;

    // Largest offset a frame byte can have (length 255 plus two sync bytes).
    localparam logic [OFFSET_W-1:0] MAX_OFFSET = 9'd257;

endpackage

### rtl/core/sync_length_sum_frame_parser_core.sv
// Serial frame parser: two sync bytes, a length byte, body bytes and an additive checksum.
// Depends on slsfp_pkg for status codes, register indexes and widths.
//
// Usage:
//   Received bytes enter on the s_ stream channel, one byte per transaction, with the
//   restart flag in s_tuser. Every accepted byte produces exactly one result transaction
//   on the m_ channel: the parse status in m_tuser and the byte offset and echoed byte
//   in m_tdata.
//   An accepted byte waits in the input register; the parse step then writes the result
//   register behind m_tvalid. Throughput is one byte per cycle while results are taken;
//   the parse step is one compare and one 8-bit add on the input register. The input
//   register takes a new byte while a result waits, so one byte can be buffered during
//   a stall. When the result stays stalled, the input register holds and s_tready drops
//   until the result is taken. The user must write the two sync byte values through the
//   cfg_ port only while the block is idle; the block does not enforce it.
//   A synchronous active-low reset empties both registers, returns the parser to
//   hunting for the first sync byte and restores the sync values to 0xA5 and 0x5A.
`timescale 1ns / 1ps

module sync_length_sum_frame_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [7:0]  cfg_wr_data,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    input  logic [0:0]  s_tuser,      // [0] restart
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [8:0] byte_offset, [16:9] echoed_byte, [23:17] zero
    output logic [1:0]  m_tuser       // [1:0] parse_status
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_LEN   = 2'd2,
        PH_BODY  = 2'd3
    } phase_t;

    // Configuration registers
    logic [slsfp_pkg::BYTE_W-1:0]   first_sync_reg;
    logic [slsfp_pkg::BYTE_W-1:0]   second_sync_reg;

    // Input register
    logic                           in_valid_reg;
    logic [slsfp_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                           in_restart_reg;

    // Parser state
    phase_t                         phase_reg;
    phase_t                         phase_next;
    logic [slsfp_pkg::BYTE_W-1:0]   sum_reg;
    logic [slsfp_pkg::BYTE_W-1:0]   sum_next;
    logic [slsfp_pkg::BYTE_W-1:0]   len_reg;
    logic [slsfp_pkg::BYTE_W-1:0]   len_next;
    logic [slsfp_pkg::OFFSET_W-1:0] pos_reg;
    logic [slsfp_pkg::OFFSET_W-1:0] pos_next;

    // Result register
    logic                           out_valid_reg;
    logic [slsfp_pkg::STATUS_W-1:0] out_status_reg;
    logic [slsfp_pkg::STATUS_W-1:0] out_status_next;
    logic [slsfp_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [slsfp_pkg::OFFSET_W-1:0] out_offset_next;
    logic [slsfp_pkg::BYTE_W-1:0]   out_byte_reg;

    logic                           advance;
    phase_t                         cur_phase;
    logic [slsfp_pkg::OFFSET_W-1:0] cur_pos;
    logic [slsfp_pkg::OFFSET_W-1:0] last_pos;

    // The parse step runs when the input register holds a byte and the result slot frees.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_byte_reg, out_offset_reg};
    assign m_tuser  = out_status_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_sync_reg  <= slsfp_pkg::FIRST_SYNC_RESET;
            second_sync_reg <= slsfp_pkg::SECOND_SYNC_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == slsfp_pkg::CFG_IDX_FIRST_SYNC) begin
                first_sync_reg <= cfg_wr_data;
            end
            if (cfg_wr_index == slsfp_pkg::CFG_IDX_SECOND_SYNC) begin
                second_sync_reg <= cfg_wr_data;
            end
        end
    end

    // A restart drops the partial frame and judges this byte as offset zero.
    assign cur_phase = in_restart_reg ? PH_HUNT : phase_reg;
    assign cur_pos   = in_restart_reg ? '0 : pos_reg;
    assign last_pos  = slsfp_pkg::OFFSET_W'(len_reg) + slsfp_pkg::OFFSET_W'(2);

    // One parse step on the byte in the input register.
    always_comb begin
        phase_next      = cur_phase;
        pos_next        = cur_pos;
        sum_next        = sum_reg;
        len_next        = len_reg;
        out_status_next = slsfp_pkg::STATUS_BUSY;
        out_offset_next = cur_pos;
        case (cur_phase)
            PH_HUNT: begin
                out_offset_next = slsfp_pkg::OFFSET_W'(0);
                if (in_byte_reg == first_sync_reg) begin
                    phase_next = PH_SYNC2;
                    pos_next   = slsfp_pkg::OFFSET_W'(1);
                end else begin
                    out_status_next = slsfp_pkg::STATUS_ERROR;
                    phase_next      = PH_HUNT;
                    pos_next        = '0;
                end
            end
            PH_SYNC2: begin
                out_offset_next = slsfp_pkg::OFFSET_W'(1);
                if (in_byte_reg == second_sync_reg) begin
                    phase_next = PH_LEN;
                    pos_next   = slsfp_pkg::OFFSET_W'(2);
                end else begin
                    out_status_next = slsfp_pkg::STATUS_ERROR;
                    phase_next      = PH_HUNT;
                    pos_next        = '0;
                end
            end
            PH_LEN: begin
                out_offset_next = slsfp_pkg::OFFSET_W'(2);
                len_next        = in_byte_reg;
                sum_next        = in_byte_reg;
                if (in_byte_reg == '0) begin
                    // An empty frame completes on its length byte.
                    out_status_next = slsfp_pkg::STATUS_DONE;
                    phase_next      = PH_HUNT;
                    pos_next        = '0;
                end else begin
                    phase_next = PH_BODY;
                    pos_next   = slsfp_pkg::OFFSET_W'(3);
                end
            end
            PH_BODY: begin
                if (cur_pos >= last_pos) begin
                    // Checksum byte: compare against the running sum.
                    out_status_next = (sum_reg == in_byte_reg) ? slsfp_pkg::STATUS_DONE
                                                               : slsfp_pkg::STATUS_ERROR;
                    phase_next      = PH_HUNT;
                    pos_next        = '0;
                end else begin
                    sum_next = sum_reg + in_byte_reg;
                    pos_next = cur_pos + slsfp_pkg::OFFSET_W'(1);
                end
            end
            default: begin
                phase_next = PH_HUNT;
                pos_next   = '0;
            end
        endcase
    end

    // Input register, parser state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HUNT;
            sum_reg       <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg   <= 1'b1;
                in_byte_reg    <= s_tdata;
                in_restart_reg <= s_tuser[0];
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                phase_reg      <= phase_next;
                sum_reg        <= sum_next;
                len_reg        <= len_next;
                pos_reg        <= pos_next;
                out_valid_reg  <= 1'b1;
                out_status_reg <= out_status_next;
                out_offset_reg <= out_offset_next;
                out_byte_reg   <= in_byte_reg;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/slsfp_checker.sv
// Port-level checker for the frame parser core, with its bind statement.
// Depends on slsfp_pkg and on the port list of sync_length_sum_frame_parser_core.
`timescale 1ns / 1ps

module slsfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // The result channel is empty in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A frame can only complete on its length byte or later.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == slsfp_pkg::STATUS_DONE |-> m_tdata[8:0] >= 9'd2)
        else $error("frame completed before its length byte");

    // Offsets stay within a maximal frame and the padding bits are zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:0] <= slsfp_pkg::MAX_OFFSET && m_tdata[23:17] == 7'd0)
        else $error("result offset out of range or padding set");

endmodule

bind sync_length_sum_frame_parser_core slsfp_checker u_slsfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/sync_length_sum_frame_parser_core_tb.sv
// Self-checking testbench for the two-sync-byte, length and additive-checksum frame parser.
// Drives byte transactions with random gaps and stalls and checks every result against a predictor.
// Depends on slsfp_pkg and sync_length_sum_frame_parser_core.
`timescale 1ns / 1ps

module sync_length_sum_frame_parser_core_tb;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 12;
    localparam int PIPE_CYCLES = 4;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // Parser phases, mirrored from the block's state.
    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        TAKE_BODY
    } parse_phase_t;

    typedef struct packed {
        logic [slsfp_pkg::STATUS_W-1:0] status;
        logic [slsfp_pkg::OFFSET_W-1:0] offset;
        logic [slsfp_pkg::BYTE_W-1:0]   echo;
    } parse_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = slsfp_pkg::CFG_IDX_FIRST_SYNC;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] rx_byte
    logic [0:0]  s_tuser = 1'b0;       // [0] restart
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;              // [8:0] byte_offset, [16:9] echoed_byte, [23:17] zero
    logic [1:0]  m_tuser;              // [1:0] parse_status

    // Predictor copy of the sync registers and the parser state.
    logic [7:0]   sync_first;
    logic [7:0]   sync_second;
    parse_phase_t model_phase;
    logic [7:0]   model_sum;
    logic [7:0]   model_len;
    logic [8:0]   model_pos;

    parse_result_t awaited_results[$];
    parse_result_t got_result;
    parse_result_t want_result;

    int  mismatches = 0;
    int  bytes_sent = 0;
    int  restarts_sent = 0;
    int  frames_done = 0;
    int  error_results = 0;
    int  sync_writes = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  gaps_on = 1'b0;
    bit  stalls_on = 1'b0;

    sync_length_sum_frame_parser_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // Parse one byte in the predictor and return the result it must produce.
    function automatic parse_result_t next_parse_result(input logic [7:0] rx, input logic rst);
        parse_result_t r;
        r.status = slsfp_pkg::STATUS_BUSY;
        r.echo   = rx;
        if (rst) begin
            model_phase = HUNT_FIRST;
            model_pos   = '0;
        end
        r.offset = model_pos;
        case (model_phase)
            HUNT_FIRST: begin
                r.offset = 9'd0;
                if (rx == sync_first) begin
                    model_phase = HUNT_SECOND;
                    model_pos   = 9'd1;
                end else begin
                    r.status  = slsfp_pkg::STATUS_ERROR;
                    model_pos = '0;
                end
            end
            HUNT_SECOND: begin
                r.offset = 9'd1;
                if (rx == sync_second) begin
                    model_phase = TAKE_LENGTH;
                    model_pos   = 9'd2;
                end else begin
                    r.status    = slsfp_pkg::STATUS_ERROR;
                    model_phase = HUNT_FIRST;
                    model_pos   = '0;
                end
            end
            TAKE_LENGTH: begin
                r.offset  = 9'd2;
                model_len = rx;
                model_sum = rx;
                if (rx == 8'd0) begin
                    r.status    = slsfp_pkg::STATUS_DONE;
                    model_phase = HUNT_FIRST;
                    model_pos   = '0;
                end else begin
                    model_phase = TAKE_BODY;
                    model_pos   = 9'd3;
                end
            end
            default: begin
                // The checksum byte sits at offset length + 2.
                if (model_pos >= {1'b0, model_len} + 9'd2) begin
                    r.status    = (model_sum == rx) ? slsfp_pkg::STATUS_DONE
                                                    : slsfp_pkg::STATUS_ERROR;
                    model_phase = HUNT_FIRST;
                    model_pos   = '0;
                end else begin
                    model_sum = model_sum + rx;
                    model_pos = model_pos + 9'd1;
                end
            end
        endcase
        return r;
    endfunction

    // Receiver side: random stall bursts on m_tready while enabled.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (stalls_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 17);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest awaited result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.status = m_tuser;
            got_result.offset = m_tdata[8:0];
            got_result.echo   = m_tdata[16:9];
            if (got_result.status == slsfp_pkg::STATUS_DONE) frames_done++;
            if (got_result.status == slsfp_pkg::STATUS_ERROR) error_results++;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result: status %0d offset %0d byte %02h",
                             got_result.status, got_result.offset, got_result.echo);
            end else begin
                want_result = awaited_results.pop_front();
                if (got_result !== want_result) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: expected %0d/%0d/%02h got %0d/%0d/%02h (st/off/byte)",
                                 want_result.status, want_result.offset, want_result.echo,
                                 got_result.status, got_result.offset, got_result.echo);
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("sync_length_sum_frame_parser_core_tb: errors");
            $finish;
        end
    end

    // Send one byte transaction, with an occasional gap before it.
    task automatic send_byte(input logic [7:0] rx, input logic rst);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tuser  <= rst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        awaited_results.push_back(next_parse_result(rx, rst));
        bytes_sent++;
        if (rst) restarts_sent++;
    endtask

    // Stop sending and wait until every awaited result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
    endtask

    // Bring the block to idle so that a register write is safe.
    task automatic settle_idle();
        wait_drained();
        repeat (PIPE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sync(input logic idx, input logic [7:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == slsfp_pkg::CFG_IDX_FIRST_SYNC)
            sync_first = val;
        else
            sync_second = val;
        sync_writes++;
    endtask

    // A whole frame with random body; the checksum can be spoiled on request.
    task automatic send_frame(input logic [7:0] len, input bit bad_sum, input logic rst);
        logic [7:0] sum;
        logic [7:0] b;
        send_byte(sync_first, rst);
        send_byte(sync_second, 1'b0);
        send_byte(len, 1'b0);
        sum = len;
        for (int i = 1; i < len; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            send_byte(b, 1'b0);
        end
        if (len != 8'd0)
            send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum, 1'b0);
    endtask

    // Mostly short lengths, now and then zero or a long one.
    function automatic logic [7:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 8'd0;
        if (roll < 8) return 8'($urandom_range(40, 255));
        return 8'($urandom_range(1, 12));
    endfunction

    // Directed checks with the reset sync values.
    task automatic test_directed_cases();
        // Good frame of length two with the largest byte value.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        // A zero length completes at the length byte.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        // Wrong first sync byte.
        send_byte(8'h00, 1'b0);
        // Wrong second sync byte; the byte after it is judged as a first sync byte.
        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        // Checksum mismatch.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        // Restart in the middle of a frame, then a good frame of length one.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h01, 1'b0);
    endtask

    // The longest frame reaches the largest offset.
    task automatic test_longest_frame();
        send_frame(8'hFF, 1'b0, 1'b0);
    endtask

    // Extreme and equal sync values.
    task automatic test_sync_registers();
        settle_idle();
        write_sync(slsfp_pkg::CFG_IDX_FIRST_SYNC, 8'h00);
        write_sync(slsfp_pkg::CFG_IDX_SECOND_SYNC, 8'hFF);
        send_frame(8'd1, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        settle_idle();
        write_sync(slsfp_pkg::CFG_IDX_FIRST_SYNC, 8'hFF);
        write_sync(slsfp_pkg::CFG_IDX_SECOND_SYNC, 8'hFF);
        send_frame(8'd2, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Random traffic in several sync settings: mostly well-formed frames.
    task automatic send_random_mix(input int count);
        int goal;
        int roll;
        logic [7:0] len;
        goal = bytes_sent + count;
        while (bytes_sent < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 62) begin
                send_frame(pick_length(), 1'b0, $urandom_range(0, 5) == 0);
            end else if (roll < 72) begin
                send_frame(pick_length(), 1'b1, $urandom_range(0, 5) == 0);
            end else if (roll < 80) begin
                // Broken sync pair.
                send_byte($urandom_range(0, 1) ? sync_first : 8'($urandom),
                          1'($urandom_range(0, 1)));
                send_byte(8'($urandom), 1'b0);
            end else if (roll < 88) begin
                // Truncated frame dropped by a restart.
                len = 8'($urandom_range(3, 12));
                send_byte(sync_first, 1'b0);
                send_byte(sync_second, 1'b0);
                send_byte(len, 1'b0);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
                send_frame(pick_length(), 1'b0, 1'b1);
            end else if (roll < 97) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
                wait_drained();
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 5; ph++) begin
            settle_idle();
            case (ph)
                0: begin
                    write_sync(slsfp_pkg::CFG_IDX_FIRST_SYNC, slsfp_pkg::FIRST_SYNC_RESET);
                    write_sync(slsfp_pkg::CFG_IDX_SECOND_SYNC, slsfp_pkg::SECOND_SYNC_RESET);
                end
                1: begin
                    write_sync(slsfp_pkg::CFG_IDX_FIRST_SYNC, 8'h00);
                    write_sync(slsfp_pkg::CFG_IDX_SECOND_SYNC, 8'hFF);
                end
                2: begin
                    write_sync(slsfp_pkg::CFG_IDX_FIRST_SYNC, 8'hFF);
                    write_sync(slsfp_pkg::CFG_IDX_SECOND_SYNC, 8'h00);
                end
                3: begin
                    write_sync(slsfp_pkg::CFG_IDX_FIRST_SYNC, 8'($urandom));
                    write_sync(slsfp_pkg::CFG_IDX_SECOND_SYNC, 8'($urandom));
                end
                default: begin
                    write_sync(slsfp_pkg::CFG_IDX_FIRST_SYNC, 8'($urandom));
                    write_sync(slsfp_pkg::CFG_IDX_SECOND_SYNC, sync_first);
                end
            endcase
            // The third and the last settings run without gaps or stalls.
            gaps_on = (ph != 2) && (ph != 4);
            stalls_on <= (ph != 2) && (ph != 4);
            send_random_mix(50);
        end
    endtask

    initial begin
        sync_first  = slsfp_pkg::FIRST_SYNC_RESET;
        sync_second = slsfp_pkg::SECOND_SYNC_RESET;
        model_phase = HUNT_FIRST;
        model_sum   = '0;
        model_len   = '0;
        model_pos   = '0;
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        gaps_on = 1'b1;
        stalls_on <= 1'b1;
        test_directed_cases();
        test_longest_frame();
        test_sync_registers();
        test_random_traffic();

        wait_drained();
        repeat (PIPE_CYCLES * 2) @(posedge aclk);
        if (awaited_results.size() != 0) mismatches++;

        $display("Sent %0d bytes (%0d with restart) over %0d sync register writes.",
                 bytes_sent, restarts_sent, sync_writes);
        $display("Saw %0d completed frames and %0d error results; %0d mismatches.",
                 frames_done, error_results, mismatches);
        if (mismatches == 0)
            $display("sync_length_sum_frame_parser_core_tb: clean");
        else
            $display("sync_length_sum_frame_parser_core_tb: errors");
        $finish;
    end

endmodule

### sim.f
rtl/core/slsfp_pkg.sv
rtl/core/sync_length_sum_frame_parser_core.sv
rtl/core/slsfp_checker.sv
verif/sync_length_sum_frame_parser_core_tb.sv
